// ===== sv/crc32wic_pkg.sv =====
// Package for the word-wise CRC-32 image checker.
// Holds widths, reset values, the register map and the CRC helper functions.
// No dependencies; every other file of the block imports it.
package crc32wic_pkg;

	// CRC width and the width of a column index into the update matrix
	localparam int CRC_W = 32;
	localparam int COL_W = $clog2(CRC_W);

	// Register reset values
	localparam logic [CRC_W-1:0] CRC_POLY_RST   = 32'h04C1_1DB7;
	localparam logic [CRC_W-1:0] CRC_START_RST  = 32'hFFFF_FFFF;
	localparam logic [CRC_W-1:0] CRC_EXPECT_RST = 32'h0000_0000;

	// Configuration port widths
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef logic [CRC_W-1:0] crc_t;

	// One column per input bit: column j is x^(32+j) mod P
	typedef logic [CRC_W-1:0][CRC_W-1:0] crc_mat_t;

	// Register indexes (word address, paddr[3:2])
	typedef enum logic [1:0] {
		REG_POLY   = 2'd0,
		REG_START  = 2'd1,
		REG_EXPECT = 2'd2
	} reg_idx_t;

	// Current configuration as seen by the datapath
	typedef struct packed {
		crc_t poly;
		crc_t start;
		crc_t exp_crc;
	} cfg_t;

	// One MSB-first shift step with conditional reduction by the polynomial
	function automatic crc_t crc_step(crc_t c, crc_t poly);
		crc_t sh;
		sh = {c[CRC_W-2:0], 1'b0};
		return c[CRC_W-1] ? (sh ^ poly) : sh;
	endfunction

	// Multiply a 32-bit value by the update matrix over GF(2)
	function automatic crc_t crc_mat_apply(crc_mat_t mat, crc_t c);
		crc_t acc;
		acc = '0;
		for (int j = 0; j < CRC_W; j++) begin
			if (c[j]) begin
				acc = acc ^ mat[j];
			end
		end
		return acc;
	endfunction

endpackage

// ===== sv/crc32wic_regs.sv =====
// Configuration registers of the CRC-32 image checker behind an APB-style port.
// Depends on crc32wic_pkg for the register map and reset values.
// Flags a polynomial write so the update matrix can be rebuilt.
module crc32wic_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [crc32wic_pkg::APB_AW-1:0]     paddr,
	input  logic [crc32wic_pkg::APB_DW-1:0]     pwdata,
	output logic [crc32wic_pkg::APB_DW-1:0]     prdata,
	output logic                                pready,
	output crc32wic_pkg::cfg_t                  cfg,
	output logic                                poly_upd
);
	import crc32wic_pkg::*;

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;
	logic     poly_upd_q;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[3:2]);

	// Register writes; an address past the map is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly    <= CRC_POLY_RST;
			cfg_q.start   <= CRC_START_RST;
			cfg_q.exp_crc <= CRC_EXPECT_RST;
			poly_upd_q    <= 1'b0;
		end else begin
			poly_upd_q <= 1'b0;
			if (wr_en) begin
				unique case (idx)
					REG_POLY: begin
						cfg_q.poly <= pwdata;
						poly_upd_q <= 1'b1;
					end
					REG_START:  cfg_q.start   <= pwdata;
					REG_EXPECT: cfg_q.exp_crc <= pwdata;
					default: ;
				endcase
			end
		end
	end

	// Read data
	always_comb begin
		unique case (idx)
			REG_POLY:   prdata = cfg_q.poly;
			REG_START:  prdata = cfg_q.start;
			REG_EXPECT: prdata = cfg_q.exp_crc;
			default:    prdata = '0;
		endcase
	end

	assign cfg      = cfg_q;
	assign poly_upd = poly_upd_q;

endmodule

// ===== sv/crc32wic_matrix.sv =====
// Builder for the 32x32 GF(2) matrix that performs 32 CRC shift steps at once.
// Depends on crc32wic_pkg. Rebuilds one column per cycle after reset and after
// every polynomial write; ready is low while the sweep runs.
module crc32wic_matrix (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crc32wic_pkg::crc_t         poly,
	input  logic                       poly_upd,
	output crc32wic_pkg::crc_mat_t     mat,
	output logic                       ready
);
	import crc32wic_pkg::*;

	crc_mat_t         mat_q;
	logic             build_q;
	logic [COL_W-1:0] col_q;
	crc_t             rem_q;

	// Column sweep control: rem_q walks x^32, x^33, ... mod P
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			build_q <= 1'b1;
			col_q   <= '0;
			rem_q   <= CRC_POLY_RST;
		end else if (poly_upd) begin
			build_q <= 1'b1;
			col_q   <= '0;
			rem_q   <= poly;
		end else if (build_q) begin
			rem_q <= crc_step(rem_q, poly);
			col_q <= col_q + 1'b1;
			if (col_q == COL_W'(CRC_W - 1)) begin
				build_q <= 1'b0;
			end
		end
	end

	// Matrix columns, written one per cycle during the sweep
	always_ff @(posedge clk) begin
		if (build_q && !poly_upd) begin
			mat_q[col_q] <= rem_q;
		end
	end

	assign mat   = mat_q;
	assign ready = !build_q && !poly_upd;

	// The sweep always ends right after the last column is written
	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		build_q && !poly_upd && (col_q == COL_W'(CRC_W - 1)) |=> !build_q || $past(poly_upd))
		else $error("column sweep did not finish after the last column");

endmodule

// ===== sv/crc32wic_core.sv =====
// Datapath of the CRC-32 image checker: input register, matrix
// update of the running CRC, and the result register.
// Depends on crc32wic_pkg for the matrix type and the update function.
module crc32wic_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  crc32wic_pkg::cfg_t         cfg,
	input  crc32wic_pkg::crc_mat_t     mat,
	input  logic                       tbl_ready,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  crc32wic_pkg::crc_t         s_tdata,
	input  logic                       s_tlast,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output crc32wic_pkg::crc_t         m_tdata,
	output logic                       m_tlast,
	output logic                       m_tuser
);
	import crc32wic_pkg::*;

	logic valid_s1;
	crc_t data_s1;
	logic last_s1;
	logic valid_s2;
	crc_t crc_s2;
	logic last_s2;
	logic match_s2;
	crc_t crc_q;
	crc_t crc_new;
	logic load_s2;
	logic adv_s1;
	logic take;

	// Handshake between the stages
	assign load_s2  = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && load_s2;
	assign s_tready = tbl_ready && (!valid_s1 || adv_s1);
	assign take     = s_tvalid && s_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// All 32 shift steps as one matrix product
	assign crc_new = crc_mat_apply(mat, crc_q ^ data_s1);

	// Running CRC, reloaded with the start value after the last word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_START_RST;
		end else if (adv_s1) begin
			crc_q <= last_s1 ? cfg.start : crc_new;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			crc_s2   <= crc_new;
			last_s2  <= last_s1;
			match_s2 <= last_s1 && (crc_new == cfg.exp_crc);
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = crc_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = match_s2;

	// A match is only ever reported on the last word of an image
	a_match_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("match flag set on a word that is not last");

	// After the last word leaves the input stage the CRC holds the start value
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> crc_q == $past(cfg.start))
		else $error("running CRC not reloaded after the last word");

	// No item is taken while the update matrix is being rebuilt
	a_no_take_build: assert property (@(posedge clk) disable iff (!arst_n)
		!tbl_ready |-> !take)
		else $error("item accepted during matrix rebuild");

	// An item in the input stage is never dropped while the result side stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("input stage item lost during a stall");

endmodule

// ===== sv/crc32_word_image_check.sv =====
// Word-wise CRC-32 image checker, top level.
// Depends on crc32wic_pkg, crc32wic_regs, crc32wic_matrix and crc32wic_core.
//
//   Channel   Direction  Handshake          Contents
//   s_*       in         tvalid / tready    tdata: data_word; tlast: last_word
//   m_*       out        tvalid / tready    tdata: crc_value; tlast: is_last;
//                                           tuser: crc_match
//   APB       in         psel / penable     polynomial 0x0, start_value 0x4,
//                                           expected_crc 0x8
//
// One item per cycle sustained while m_tready is high and the matrix is ready;
// an accepted item passes the input register, then the result register, before
// its result is on m_*. The running CRC loops through a single 32x32 XOR matrix.
// After reset and after each polynomial write the matrix is rebuilt one column
// per cycle; s_tready stays low during the rebuild. Reset is asynchronous
// and active low. A stall on m_tready holds the result register, then the
// input register.
module crc32_word_image_check (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB-style configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [crc32wic_pkg::APB_AW-1:0] paddr,
	input  logic [crc32wic_pkg::APB_DW-1:0] pwdata,
	output logic [crc32wic_pkg::APB_DW-1:0] prdata,
	output logic                            pready,
	// Input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [31:0]                     s_tdata,  // [31:0] data_word
	input  logic                            s_tlast,
	// Result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [31:0]                     m_tdata,  // [31:0] crc_value
	output logic                            m_tlast,
	output logic                            m_tuser   // [0] crc_match
);
	import crc32wic_pkg::*;

	cfg_t     cfg;
	logic     poly_upd;
	crc_mat_t mat;
	logic     tbl_ready;

	// Configuration registers
	crc32wic_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.cfg      (cfg),
		.poly_upd (poly_upd)
	);

	// Update matrix for the current polynomial
	crc32wic_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.poly     (cfg.poly),
		.poly_upd (poly_upd),
		.mat      (mat),
		.ready    (tbl_ready)
	);

	// Item datapath
	crc32wic_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mat       (mat),
		.tbl_ready (tbl_ready),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule
